/* rtl/core/sse_pkg.sv */
// ----------------------------------------------------------------------------
// sse_pkg - shared definitions for the kinetic synapse Euler step
// Widths, register indexes, controller command bundle and the sigmoid table.
// ----------------------------------------------------------------------------
package sse_pkg;

  // sigmoid lookup, indexed by whole millivolt of the presynaptic voltage
  localparam int SIG_DEPTH = 256;
  localparam int SIG_IDX_W = $clog2(SIG_DEPTH);
  localparam int SIG_SPAN  = 30;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // shared multiplier: 32 x 17 unsigned
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // round(65536/(1+exp(0.4*k))), k = 0 .. SIG_SPAN-1
  localparam logic [15:0] SIG_HALF [SIG_SPAN] = '{
    16'd32768, 16'd26300, 16'd20318, 16'd15170, 16'd11009, 16'd7812, 16'd5451,
    16'd3757,  16'd2567,  16'd1743,  16'd1179,  16'd795,   16'd535,  16'd360,
    16'd241,   16'd162,   16'd109,   16'd73,    16'd49,    16'd33,   16'd22,
    16'd15,    16'd10,    16'd7,     16'd4,     16'd3,     16'd2,    16'd1,
    16'd1,     16'd1
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONDUCTANCE     = 3'd0,
    REG_REVERSAL        = 3'd1,
    REG_STEP_GAIN       = 3'd2,
    REG_INITIAL_RELEASE = 3'd3,
    REG_INITIAL_GATING  = 3'd4
  } cfg_reg_t;

  // operand pairs fed to the shared multiplier
  typedef enum logic [1:0] {
    MS_GS   = 2'd0,  // g * s
    MS_CUR  = 2'd1,  // (g*s) * |vpost - E|
    MS_GATE = 2'd2,  // k * |sig - r|
    MS_REL  = 2'd3   // k * |r - s|
  } mul_sel_t;

  typedef struct packed {
    logic     load;      // latch item, apply restart, look up sigmoid
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     cur_load;  // round and saturate current from product
    logic     r_load;    // gating variable takes its new value
    logic     finish;    // release variable update, result register load
  } sse_cmd_t;

  // table entry for index idx (mV = idx - SIG_DEPTH/2)
  function automatic logic [15:0] sig_entry(logic [SIG_IDX_W-1:0] idx);
    int          d;
    logic [16:0] v;
    d = int'(idx) - SIG_DEPTH / 2 + 40;
    v = '0;
    if (d <= -SIG_SPAN) begin
      return 16'd0;
    end else if (d <= 0) begin
      return SIG_HALF[-d];
    end else if (d >= SIG_SPAN) begin
      return 16'hFFFF;
    end else begin
      v = 17'h10000 - {1'b0, SIG_HALF[d]};
      return v[16] ? 16'hFFFF : v[15:0];
    end
  endfunction

endpackage

/* rtl/core/sse_if.sv */
// ----------------------------------------------------------------------------
// sse_if - valid/ready channels of the synapse step block
// Input item channel and result channel.
// ----------------------------------------------------------------------------
interface sse_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pre_voltage;
  logic signed [15:0] post_voltage;
  logic               restart;

  modport source (output valid, pre_voltage, post_voltage, restart, input ready);
  modport sink   (input valid, pre_voltage, post_voltage, restart, output ready);
endinterface

interface sse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] synaptic_current;
  logic        [15:0] release_level;

  modport source (output valid, synaptic_current, release_level, input ready);
  modport sink   (input valid, synaptic_current, release_level, output ready);
endinterface

/* rtl/core/sse_ctrl.sv */
// ----------------------------------------------------------------------------
// sse_ctrl - sequencer for one synapse step
// Steps the shared multiplier through its four products and hands the
// finished beat to the result register.
// ----------------------------------------------------------------------------
module sse_ctrl
  import sse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output sse_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GS   = 6'b000010,
    S_CUR  = 6'b000100,
    S_GATE = 6'b001000,
    S_REL  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   finish;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // result register must be empty or draining this cycle
  assign finish   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_GS;
      S_GS:    state_next = S_CUR;
      S_CUR:   state_next = S_GATE;
      S_GATE:  state_next = S_REL;
      S_REL:   state_next = S_FIN;
      S_FIN:   if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = accept;
    cmd.mul_sel  = MS_GS;
    cmd.finish   = finish;
    unique case (state)
      S_GS: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GS;
      end
      S_CUR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_CUR;
      end
      S_GATE: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_GATE;
        cmd.cur_load = 1'b1;
      end
      S_REL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_REL;
        cmd.r_load  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_GS)
    else $error("accepted beat did not start the multiply sequence");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid)
    else $error("finished beat not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> state == S_FIN)
    else $error("step completed over an unread result");

  a_no_mul_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_en |-> !in_ready && !cmd.finish)
    else $error("multiplier busy outside the sequence");

endmodule

/* rtl/core/sse_datapath.sv */
// ----------------------------------------------------------------------------
// sse_datapath - registers and arithmetic of the synapse step
// Config registers, s and r state, sigmoid lookup, one shared 32x17
// multiplier, rounding, clamping and current saturation.
// ----------------------------------------------------------------------------
module sse_datapath
  import sse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  sse_cmd_t             cmd,
  input  logic signed [15:0]   pre_voltage,
  input  logic signed [15:0]   post_voltage,
  input  logic                 restart,
  output logic signed [31:0]   synaptic_current,
  output logic        [15:0]   release_level
);

  logic        [15:0] conductance;
  logic signed [15:0] reversal_potential;
  logic        [15:0] step_gain;
  logic        [15:0] initial_release;
  logic        [15:0] initial_gating;

  logic [15:0] release_var;
  logic [15:0] gating_var;

  logic [15:0]        sig_val;
  logic [16:0]        vmag;
  logic               vneg;
  logic               gate_neg;
  logic               rel_neg;
  logic [MUL_P_W-1:0] prod;
  logic signed [31:0] cur;

  logic signed [7:0]  mv;
  logic signed [16:0] idx_full;
  logic [SIG_IDX_W-1:0] idx;
  logic signed [16:0] vdiff;
  logic [16:0]        gdiff;
  logic [16:0]        rdiff;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [33:0]        cur_round;
  logic signed [31:0] cur_sat;
  logic [15:0]        r_new;
  logic [15:0]        s_new;

  // x +/- round(prod / 2^16), clamped to 16 bits
  function automatic logic [15:0] euler_apply(logic [15:0] x, logic neg,
                                              logic [31:0] p);
    logic [16:0]        inc;
    logic signed [18:0] nx;
    inc = 17'((33'(p) + 33'h8000) >> 16);
    nx  = neg ? (19'(x) - 19'(inc)) : (19'(x) + 19'(inc));
    if (nx < 0) begin
      return 16'd0;
    end else if (nx > 19'sd65535) begin
      return 16'hFFFF;
    end else begin
      return nx[15:0];
    end
  endfunction

  // whole millivolt, offset into the table and clamped to its range
  assign mv       = pre_voltage[15:8];
  assign idx_full = 17'(mv) + 17'(SIG_DEPTH / 2);
  always_comb begin
    if (idx_full < 0) begin
      idx = '0;
    end else if (idx_full > 17'(SIG_DEPTH - 1)) begin
      idx = SIG_IDX_W'(SIG_DEPTH - 1);
    end else begin
      idx = idx_full[SIG_IDX_W-1:0];
    end
  end

  assign vdiff = 17'(post_voltage) - 17'(reversal_potential);
  assign gdiff = {1'b0, sig_val} - {1'b0, gating_var};
  assign rdiff = {1'b0, gating_var} - {1'b0, release_var};

  always_comb begin
    case (cmd.mul_sel)
      MS_GS: begin
        mul_a = {16'd0, conductance};
        mul_b = {1'b0, release_var};
      end
      MS_CUR: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = vmag;
      end
      MS_GATE: begin
        mul_a = {16'd0, step_gain};
        mul_b = gdiff[16] ? 17'(-gdiff) : gdiff;
      end
      default: begin
        mul_a = {16'd0, step_gain};
        mul_b = rdiff[16] ? 17'(-rdiff) : rdiff;
      end
    endcase
  end

  // current: round at Q16.16, saturate to signed 32 bits
  assign cur_round = 34'((prod + MUL_P_W'(32'h8000)) >> 16);
  always_comb begin
    if (!vneg) begin
      cur_sat = (cur_round > 34'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(cur_round[31:0]);
    end else if (cur_round >= 34'h8000_0000) begin
      cur_sat = 32'sh8000_0000;
    end else begin
      cur_sat = signed'(32'd0 - cur_round[31:0]);
    end
  end

  assign r_new = euler_apply(gating_var, gate_neg, prod[31:0]);
  assign s_new = euler_apply(release_var, rel_neg, prod[31:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      conductance        <= '0;
      reversal_potential <= '0;
      step_gain          <= '0;
      initial_release    <= '0;
      initial_gating     <= '0;
      release_var        <= '0;
      gating_var         <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CONDUCTANCE:     conductance        <= cfg_data;
          REG_REVERSAL:        reversal_potential <= signed'(cfg_data);
          REG_STEP_GAIN:       step_gain          <= cfg_data;
          REG_INITIAL_RELEASE: initial_release    <= cfg_data;
          REG_INITIAL_GATING:  initial_gating     <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && restart) begin
        release_var <= initial_release;
        gating_var  <= initial_gating;
      end
      if (cmd.r_load) begin
        gating_var <= r_new;
      end
      if (cmd.finish) begin
        release_var <= s_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sig_val <= sig_entry(idx);
      vneg    <= vdiff[16];
      vmag    <= vdiff[16] ? 17'(-vdiff) : 17'(vdiff);
    end
    if (cmd.mul_en) begin
      prod <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end
    // signs of the Euler differences, taken while old r and s are in place
    if (cmd.mul_en && cmd.mul_sel == MS_GATE) begin
      gate_neg <= gdiff[16];
    end
    if (cmd.mul_en && cmd.mul_sel == MS_REL) begin
      rel_neg <= rdiff[16];
    end
    if (cmd.cur_load) begin
      cur <= cur_sat;
    end
    if (cmd.finish) begin
      synaptic_current <= cur;
      release_level    <= s_new;
    end
  end

endmodule

/* rtl/core/sigmoid_synapse_euler_step.sv */
// ----------------------------------------------------------------------------
// sigmoid_synapse_euler_step - kinetic synapse, one forward-Euler tick a beat
//
// Each input beat on req carries pre_voltage, post_voltage (signed Q8.8 mV)
// and restart. restart reloads s and r from the initial registers first.
// The result beat on rsp carries synaptic_current = g*s*(vpost-E) from the
// s held before the step (Q16.16, saturated) and release_level, s after it.
// Config: cfg_write with cfg_index 0..4 (conductance, reversal_potential,
// step_gain, initial_release, initial_gating) and 16-bit cfg_data; other
// indexes ignored; user must write only with no beat in flight (unenforced).
// An accepted beat runs through S_GS, S_CUR, S_GATE, S_REL and S_FIN, where
// its result is registered. A new beat waits for S_IDLE: the single 32x17
// multiplier forms g*s, g*s*|dv|, k*|sig-r| and k*|r-s| in turn, between the
// load and the finish. req.ready is high only between steps.
// A result waits in its output register while rsp.ready is low; the step
// after it holds its last cycle until that register drains.
// Reset (rst, synchronous) clears s, r, all config registers and the
// result valid flag; the sigmoid table is constant logic.
// ----------------------------------------------------------------------------
module sigmoid_synapse_euler_step
  import sse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sse_in_if.sink               req,
  sse_out_if.source            rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  sse_cmd_t cmd;

  sse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  sse_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .pre_voltage      (req.pre_voltage),
    .post_voltage     (req.post_voltage),
    .restart          (req.restart),
    .synaptic_current (rsp.synaptic_current),
    .release_level    (rsp.release_level)
  );

endmodule

/* test/sse_step_checker.sv */
// ----------------------------------------------------------------------------
// sse_step_checker - result predictor and comparator for the synapse step
// Watches the config port and both channels, runs its own fixed-point model
// of the synapse tick for every accepted input beat and compares each result
// beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sse_step_checker
  import sse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sse_in_if                    req_mon,
  sse_out_if                   rsp_mon,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   in_flight
);

  localparam int REPORT_LIMIT = 40;
  localparam int TAIL_LEN     = 30;

  // 65536/(1+exp(0.4*n)) rounded, n = 0 .. TAIL_LEN-1
  localparam logic [15:0] LOGISTIC_TAIL [TAIL_LEN] = '{
    16'd32768, 16'd26300, 16'd20318, 16'd15170, 16'd11009, 16'd7812,
    16'd5451,  16'd3757,  16'd2567,  16'd1743,  16'd1179,  16'd795,
    16'd535,   16'd360,   16'd241,   16'd162,   16'd109,   16'd73,
    16'd49,    16'd33,    16'd22,    16'd15,    16'd10,    16'd7,
    16'd4,     16'd3,     16'd2,     16'd1,     16'd1,     16'd1
  };

  typedef struct packed {
    logic signed [31:0] current;
    logic        [15:0] release_level;
  } synapse_out_t;

  logic        [15:0] syn_cond;
  logic signed [15:0] syn_rev;
  logic        [15:0] syn_gain;
  logic        [15:0] syn_s_init;
  logic        [15:0] syn_r_init;
  logic        [15:0] syn_s;
  logic        [15:0] syn_r;
  synapse_out_t       due_results [$];
  int                 fail_count = 0;
  int                 beat_no = 0;

  assign mismatches = fail_count;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < REPORT_LIMIT)
      $display("result %0d: %s is %0d, want %0d", beat_no, what, got, want);
    fail_count++;
  endtask

  // steady-state activation for the whole millivolt of vpre
  function automatic logic [15:0] activation(logic signed [15:0] vpre);
    int off;
    // floor(vpre/256) spans -128..127, so the table index never clamps
    off = int'(vpre >>> 8) + 40;
    if (off <= -TAIL_LEN) return 16'h0000;
    if (off <= 0) return LOGISTIC_TAIL[-off];
    if (off >= TAIL_LEN) return 16'hFFFF;
    return 16'(17'h10000 - {1'b0, LOGISTIC_TAIL[off]});
  endfunction

  // x + k*(target - x), magnitude rounded half away from zero, clamped
  function automatic logic [15:0] euler_advance(logic [15:0] x, logic [15:0] target,
                                                logic [15:0] k);
    int               diff;
    int               inc;
    int               nx;
    longint unsigned  prod;
    diff = int'(target) - int'(x);
    prod = longint'(k) * longint'(diff < 0 ? -diff : diff);
    inc  = int'((prod + 64'd32768) >> 16);
    nx   = (diff < 0) ? int'(x) - inc : int'(x) + inc;
    if (nx < 0) nx = 0;
    if (nx > 65535) nx = 65535;
    return nx[15:0];
  endfunction

  function automatic logic signed [31:0] current_from(logic [15:0] s,
                                                       logic signed [15:0] vpost);
    int              diff;
    longint unsigned gs;
    longint unsigned mag;
    longint unsigned prod;
    diff = int'(vpost) - int'(syn_rev);
    mag  = longint'(diff < 0 ? -diff : diff);
    gs   = longint'(syn_cond) * longint'(s);
    prod = (gs * mag + 64'd32768) >> 16;
    if (diff >= 0) return (prod > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : prod[31:0];
    if (prod >= 64'h8000_0000) return 32'sh8000_0000;
    return 32'd0 - prod[31:0];
  endfunction

  always @(posedge clk) begin
    synapse_out_t seen;
    synapse_out_t due;
    logic [15:0]  s_old;
    logic [15:0]  r_old;
    if (rst) begin
      syn_cond   = '0;
      syn_rev    = '0;
      syn_gain   = '0;
      syn_s_init = '0;
      syn_r_init = '0;
      syn_s      = '0;
      syn_r      = '0;
      due_results.delete();
      in_flight <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen.current       = rsp_mon.synaptic_current;
        seen.release_level = rsp_mon.release_level;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected beat, synaptic_current", seen.current, 0);
        end else begin
          due = due_results.pop_front();
          if (seen.current !== due.current)
            report_mismatch("synaptic_current", seen.current, due.current);
          if (seen.release_level !== due.release_level)
            report_mismatch("release_level", seen.release_level, due.release_level);
        end
        beat_no++;
      end

      if (cfg_write) begin
        case (cfg_index)
          REG_CONDUCTANCE:     syn_cond   = cfg_data;
          REG_REVERSAL:        syn_rev    = cfg_data;
          REG_STEP_GAIN:       syn_gain   = cfg_data;
          REG_INITIAL_RELEASE: syn_s_init = cfg_data;
          REG_INITIAL_GATING:  syn_r_init = cfg_data;
          default: ;
        endcase
      end

      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.restart) begin
          syn_s = syn_s_init;
          syn_r = syn_r_init;
        end
        s_old = syn_s;
        r_old = syn_r;
        // current uses s from before the step; both updates use the old r
        due.current       = current_from(s_old, req_mon.post_voltage);
        syn_r             = euler_advance(r_old, activation(req_mon.pre_voltage), syn_gain);
        syn_s             = euler_advance(s_old, r_old, syn_gain);
        due.release_level = syn_s;
        due_results.push_back(due);
      end

      in_flight <= due_results.size();
    end
  end

endmodule

/* test/sigmoid_synapse_euler_step_test.sv */
// ----------------------------------------------------------------------------
// sigmoid_synapse_euler_step_test - top-level bench for the synapse step
// Directed corners (table ends, sigmoid window edges, current saturation,
// rounding ties, restart) then phases of spike-train-like random beats under
// several register settings, with random stalls on both channels outside the steady phase.
// ----------------------------------------------------------------------------
module sigmoid_synapse_euler_step_test;
  import sse_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int IDLE_PCT         = 27;
  localparam int DRAIN_CYCLES     = 10;
  localparam int PHASES           = 10;
  localparam int BEATS_PER_PHASE  = 160;
  localparam int STEADY_PHASE     = 5;
  localparam int FIRST_UNUSED_REG = int'(REG_INITIAL_GATING) + 1;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   in_flight;
  int                   cycles = 0;
  bit                   steady = 1'b0;

  sse_in_if  req_ch ();
  sse_out_if rsp_ch ();

  sigmoid_synapse_euler_step dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sse_step_checker synapse_check (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // waits until nothing is in flight before writing
  task automatic load_settings(input logic [15:0] g, input logic [15:0] e,
                               input logic [15:0] k, input logic [15:0] s0,
                               input logic [15:0] r0);
    req_ch.valid <= 1'b0;
    // in_flight lags the last accepted beat, so let it settle before polling
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, FIRST_UNUSED_REG)),
              CFG_W'($urandom));
    write_reg(REG_CONDUCTANCE, g);
    write_reg(REG_REVERSAL, e);
    write_reg(REG_STEP_GAIN, k);
    write_reg(REG_INITIAL_RELEASE, s0);
    write_reg(REG_INITIAL_GATING, r0);
    cfg_write <= 1'b0;
  endtask

  task automatic send_item(input logic [15:0] pre, input logic [15:0] post, input logic rs);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < IDLE_PCT) gap++;
    if (!steady && $urandom_range(19) == 0) gap += $urandom_range(1, 12);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.pre_voltage  <= pre;
    req_ch.post_voltage <= post;
    req_ch.restart      <= rs;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic logic [15:0] pick_setting();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // presynaptic level held for runs of beats, like a spike train, plus noise
  task automatic drive_train(input int count);
    int          run_left;
    int          level_mv;
    logic [15:0] pre;
    logic [15:0] post;
    run_left = 0;
    level_mv = -65;
    repeat (count) begin
      if (run_left == 0) begin
        level_mv = int'($urandom_range(100)) - 80;
        run_left = $urandom_range(1, 24);
      end
      run_left--;
      case ($urandom_range(9))
        0, 1:    pre = 16'($urandom);
        2:       pre = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default: pre = 16'(level_mv * 256 + int'($urandom_range(255)));
      endcase
      if ($urandom_range(9) == 0) post = $urandom_range(1) ? 16'h7FFF : 16'h8000;
      else post = 16'($urandom);
      send_item(pre, post, $urandom_range(49) == 0);
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.pre_voltage  = '0;
    req_ch.post_voltage = '0;
    req_ch.restart      = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full-scale: positive current saturation, table ends, sigmoid window
    load_settings(16'hFFFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(16'h8000, 16'h7FFF, 1'b1);
    send_item(16'h7FFF, 16'h8000, 1'b0);
    send_item(16'(-40 * 256), 16'h7FFF, 1'b0);
    send_item(16'(-40 * 256 - 1), 16'h0000, 1'b0);
    send_item(16'(-39 * 256), 16'h7FFF, 1'b1);
    send_item(16'(-69 * 256), 16'h1234, 1'b0);
    send_item(16'(-70 * 256), 16'hFFFF, 1'b0);
    send_item(16'(-11 * 256), 16'h7FFF, 1'b0);
    send_item(16'(-10 * 256), 16'h8001, 1'b0);
    send_item(16'h00FF, 16'h7FFF, 1'b0);
    send_item(16'hFFFF, 16'h7FFF, 1'b0);

    // negative current saturation, then s decaying toward r
    load_settings(16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000);
    send_item(16'hFF00, 16'h8000, 1'b1);
    send_item(16'(-60 * 256), 16'h7FFF, 1'b0);
    send_item(16'(-60 * 256), 16'hFFFF, 1'b0);
    send_item(16'(-20 * 256), 16'h8000, 1'b0);

    // everything zero
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(16'h7FFF, 16'h7FFF, 1'b1);
    send_item(16'h8000, 16'h8000, 1'b0);
    send_item(16'h5A5A, 16'hA5A5, 1'b0);

    // smallest nonzero gain, conductance and initial release: half-unit ties in the current product
    load_settings(16'h0001, 16'h0000, 16'h0001, 16'h0001, 16'hFFFF);
    send_item(16'h8000, 16'h8000, 1'b1);
    send_item(16'h8000, 16'h8000, 1'b1);
    send_item(16'h7FFF, 16'h7FFF, 1'b0);
    send_item(16'h0000, 16'h0001, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      load_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
                    pick_setting());
      steady = (p == STEADY_PHASE);
      // every phase starts from its own initial values
      send_item(16'(-65 * 256), 16'($urandom), 1'b1);
      drive_train(BEATS_PER_PHASE);
    end
    steady = 1'b0;

    req_ch.valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
